// ===== hw/rtl/ofs_pkg.sv =====
package ofs_pkg;

   // default widths of the face index and the axis coordinate
   localparam int DEFAULT_INDEX_BITS = 20;
   localparam int DEFAULT_COORD_BITS = 32;

   // the reported face index is always 20 bits wide
   localparam int FACE_OUT_BITS = 20;

   // flags that go with one result item
   typedef struct packed {
      logic flip_needed;
      logic found;
   } ofs_flags_type;

endpackage

// ===== hw/rtl/ofs_req_if.sv =====
interface ofs_req_if import ofs_pkg::*; #(
   parameter int INDEX_BITS = DEFAULT_INDEX_BITS,
   parameter int COORD_BITS = DEFAULT_COORD_BITS
) ();

   logic                         valid;
   logic                         ready;
   logic        [INDEX_BITS-1:0] face_index;
   logic signed [COORD_BITS-1:0] normal_comp;
   logic        [INDEX_BITS-1:0] vertex_id_a;
   logic        [INDEX_BITS-1:0] vertex_id_b;
   logic        [INDEX_BITS-1:0] vertex_id_c;
   logic signed [COORD_BITS-1:0] coord_a;
   logic signed [COORD_BITS-1:0] coord_b;
   logic signed [COORD_BITS-1:0] coord_c;
   logic                         last_face;

   modport source (
      output valid, face_index, normal_comp, vertex_id_a, vertex_id_b, vertex_id_c,
      output coord_a, coord_b, coord_c, last_face,
      input  ready
   );

   modport sink (
      input  valid, face_index, normal_comp, vertex_id_a, vertex_id_b, vertex_id_c,
      input  coord_a, coord_b, coord_c, last_face,
      output ready
   );

endinterface

// ===== hw/rtl/ofs_rsp_if.sv =====
interface ofs_rsp_if import ofs_pkg::*; ();

   logic                     valid;
   logic                     ready;
   logic [FACE_OUT_BITS-1:0] outer_face;
   logic                     flip_needed;
   logic                     found;

   modport source (
      output valid, outer_face, flip_needed, found,
      input  ready
   );

   modport sink (
      input  valid, outer_face, flip_needed, found,
      output ready
   );

endinterface

// ===== hw/rtl/ofs_corner_step.sv =====
module ofs_corner_step import ofs_pkg::*; #(
   parameter int INDEX_BITS = DEFAULT_INDEX_BITS,
   parameter int COORD_BITS = DEFAULT_COORD_BITS
) (
   input  logic                         lead_valid,
   input  logic        [INDEX_BITS-1:0] lead_vertex,
   input  logic signed [COORD_BITS-1:0] lead_coord,
   input  logic        [INDEX_BITS-1:0] lead_face,
   input  logic        [COORD_BITS-1:0] lead_mag,
   input  logic                         lead_flip,
   input  logic        [INDEX_BITS-1:0] face,
   input  logic        [COORD_BITS-1:0] mag,
   input  logic                         neg,
   input  logic        [INDEX_BITS-1:0] vid,
   input  logic signed [COORD_BITS-1:0] coord,
   output logic                         next_valid,
   output logic        [INDEX_BITS-1:0] next_vertex,
   output logic signed [COORD_BITS-1:0] next_coord,
   output logic        [INDEX_BITS-1:0] next_face,
   output logic        [COORD_BITS-1:0] next_mag,
   output logic                         next_flip
);

   always_comb begin
      next_valid  = lead_valid;
      next_vertex = lead_vertex;
      next_coord  = lead_coord;
      next_face   = lead_face;
      next_mag    = lead_mag;
      next_flip   = lead_flip;
      if (lead_valid && (vid == lead_vertex)) begin
         // repeat of the leading vertex: compete on normal magnitude
         if (mag > lead_mag) begin
            next_face = face;
            next_mag  = mag;
            next_flip = neg;
         end else if (mag == lead_mag) begin
            if (!neg) begin
               if (lead_flip || (face > lead_face)) begin
                  next_face = face;
                  next_flip = 1'b0;
               end
            end else if (lead_flip && (face < lead_face)) begin
               next_face = face;
               next_flip = 1'b1;
            end
         end
      end else if (!lead_valid || (coord > lead_coord)) begin
         // first corner, or a new strictly higher corner, takes the lead
         next_valid  = 1'b1;
         next_vertex = vid;
         next_coord  = coord;
         next_face   = face;
         next_mag    = mag;
         next_flip   = neg;
      end
   end

endmodule

// ===== hw/rtl/ofs_face_engine.sv =====
module ofs_face_engine import ofs_pkg::*; #(
   parameter int INDEX_BITS = DEFAULT_INDEX_BITS,
   parameter int COORD_BITS = DEFAULT_COORD_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   ofs_req_if.sink                  req,
   input  logic                     out_busy,
   output logic                     res_valid,
   output logic [FACE_OUT_BITS-1:0] res_face,
   output ofs_flags_type            res_flags
);

   localparam int KEEP_BITS = (INDEX_BITS < FACE_OUT_BITS) ? INDEX_BITS : FACE_OUT_BITS;

   // input register
   logic                         s1_valid_ff;
   logic        [INDEX_BITS-1:0] face_ff;
   logic signed [COORD_BITS-1:0] normal_ff;
   logic        [INDEX_BITS-1:0] vid_ff   [3];
   logic signed [COORD_BITS-1:0] coord_ff [3];
   logic                         last_ff;

   // leading corner
   logic                         lead_valid_ff, lead_valid_in;
   logic        [INDEX_BITS-1:0] lead_vertex_ff, lead_vertex_in;
   logic signed [COORD_BITS-1:0] lead_coord_ff, lead_coord_in;
   logic        [INDEX_BITS-1:0] lead_face_ff, lead_face_in;
   logic        [COORD_BITS-1:0] lead_mag_ff, lead_mag_in;
   logic                         lead_flip_ff, lead_flip_in;

   // corner chain, entry 0 is the held lead
   logic                         ch_valid  [4];
   logic        [INDEX_BITS-1:0] ch_vertex [4];
   logic signed [COORD_BITS-1:0] ch_coord  [4];
   logic        [INDEX_BITS-1:0] ch_face   [4];
   logic        [COORD_BITS-1:0] ch_mag    [4];
   logic                         ch_flip   [4];

   logic                  advance;
   logic                  accept;
   logic                  neg;
   logic [COORD_BITS-1:0] mag;
   logic                  skip;

   assign advance   = s1_valid_ff && !(last_ff && out_busy);
   assign req.ready = !s1_valid_ff || advance;
   assign accept    = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         face_ff     <= req.face_index;
         normal_ff   <= req.normal_comp;
         vid_ff[0]   <= req.vertex_id_a;
         vid_ff[1]   <= req.vertex_id_b;
         vid_ff[2]   <= req.vertex_id_c;
         coord_ff[0] <= req.coord_a;
         coord_ff[1] <= req.coord_b;
         coord_ff[2] <= req.coord_c;
         last_ff     <= req.last_face;
      end
   end

   assign skip = (normal_ff == '0);
   assign neg  = normal_ff[COORD_BITS-1];
   assign mag  = neg ? (~normal_ff + 1'b1) : normal_ff;

   assign ch_valid[0]  = lead_valid_ff;
   assign ch_vertex[0] = lead_vertex_ff;
   assign ch_coord[0]  = lead_coord_ff;
   assign ch_face[0]   = lead_face_ff;
   assign ch_mag[0]    = lead_mag_ff;
   assign ch_flip[0]   = lead_flip_ff;

   for (genvar k = 0; k < 3; k++) begin : g_corner
      ofs_corner_step #(
         .INDEX_BITS (INDEX_BITS),
         .COORD_BITS (COORD_BITS)
      ) u_step (
         .lead_valid  (ch_valid[k]),
         .lead_vertex (ch_vertex[k]),
         .lead_coord  (ch_coord[k]),
         .lead_face   (ch_face[k]),
         .lead_mag    (ch_mag[k]),
         .lead_flip   (ch_flip[k]),
         .face        (face_ff),
         .mag         (mag),
         .neg         (neg),
         .vid         (vid_ff[k]),
         .coord       (coord_ff[k]),
         .next_valid  (ch_valid[k+1]),
         .next_vertex (ch_vertex[k+1]),
         .next_coord  (ch_coord[k+1]),
         .next_face   (ch_face[k+1]),
         .next_mag    (ch_mag[k+1]),
         .next_flip   (ch_flip[k+1])
      );
   end

   // zero normal leaves the lead untouched
   always_comb begin
      if (skip) begin
         lead_valid_in  = lead_valid_ff;
         lead_vertex_in = lead_vertex_ff;
         lead_coord_in  = lead_coord_ff;
         lead_face_in   = lead_face_ff;
         lead_mag_in    = lead_mag_ff;
         lead_flip_in   = lead_flip_ff;
      end else begin
         lead_valid_in  = ch_valid[3];
         lead_vertex_in = ch_vertex[3];
         lead_coord_in  = ch_coord[3];
         lead_face_in   = ch_face[3];
         lead_mag_in    = ch_mag[3];
         lead_flip_in   = ch_flip[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_valid_ff <= 1'b0;
      end else if (advance) begin
         lead_valid_ff <= last_ff ? 1'b0 : lead_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lead_vertex_ff <= lead_vertex_in;
         lead_coord_ff  <= lead_coord_in;
         lead_face_ff   <= lead_face_in;
         lead_mag_ff    <= lead_mag_in;
         lead_flip_ff   <= lead_flip_in;
      end
   end

   assign res_valid             = advance && last_ff;
   assign res_face              = lead_valid_in ?
                                  FACE_OUT_BITS'(lead_face_in[KEEP_BITS-1:0]) : '0;
   assign res_flags.flip_needed = lead_valid_in && lead_flip_in;
   assign res_flags.found       = lead_valid_in;

`ifndef SYNTH
   a_accept_when_full : assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && s1_valid_ff) |-> advance)
      else $error("item accepted over a held item");

   a_clear_after_last : assert property (@(posedge clock) disable iff (reset)
      (advance && last_ff) |=> !lead_valid_ff)
      else $error("lead not cleared after last face");
`endif

endmodule

// ===== hw/rtl/outer_facet_select.sv =====
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+------------------------------------------
// req      | in  | req.valid/ready    | face index, normal, three corners, last
// rsp      | out | rsp.valid/ready    | outer_face, flip_needed, found
//
// one face is taken every cycle unless a last face is held; an item passes
// the input register and the three-corner compare chain; the result of a
// last face goes into the result register as it leaves the input register
// a last face is held in the input register only while the result register
// still holds an item not taken; other faces never wait on rsp
// reset is synchronous, active high, and clears valid flags and the lead
module outer_facet_select import ofs_pkg::*; #(
   parameter int INDEX_BITS = DEFAULT_INDEX_BITS,
   parameter int COORD_BITS = DEFAULT_COORD_BITS
) (
   input  logic       clock,
   input  logic       reset,
   ofs_req_if.sink    req,
   ofs_rsp_if.source  rsp
);

   logic                     res_valid;
   logic [FACE_OUT_BITS-1:0] res_face;
   ofs_flags_type            res_flags;
   logic                     out_busy;

   // result register
   logic                     rsp_valid_ff;
   logic [FACE_OUT_BITS-1:0] rsp_face_ff;
   ofs_flags_type            rsp_flags_ff;

   // engine stalls a last face only while the result item is not taken
   assign out_busy = rsp_valid_ff && !rsp.ready;

   ofs_face_engine #(
      .INDEX_BITS (INDEX_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .out_busy  (out_busy),
      .res_valid (res_valid),
      .res_face  (res_face),
      .res_flags (res_flags)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_face_ff  <= res_face;
         rsp_flags_ff <= res_flags;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.outer_face  = rsp_face_ff;
   assign rsp.flip_needed = rsp_flags_ff.flip_needed;
   assign rsp.found       = rsp_flags_ff.found;

`ifndef SYNTH
   // a new result never lands on one still waiting
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !(rsp.valid && !rsp.ready))
      else $error("result item overwritten");

   // nothing found reports a zero face and no flip
   a_empty_result : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.found) |-> ((rsp.outer_face == '0) && !rsp.flip_needed))
      else $error("empty result carries a face");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import ofs_pkg::*;

   localparam int IB = DEFAULT_INDEX_BITS;
   localparam int CB = DEFAULT_COORD_BITS;

   // run limit, far above the slowest correct run
   localparam int CYCLE_LIMIT = 200000;
   // cycles the result side stays blocked during the back-pressure test
   localparam int HOLD_CYCLES = 300;
   // cycles allowed for stray results after the last expected one
   localparam int DRAIN_CYCLES = 20;

   localparam logic [IB-1:0] INDEX_MAX = {IB{1'b1}};
   localparam logic signed [CB-1:0] COORD_MAX = {1'b0, {CB-1{1'b1}}};
   localparam logic signed [CB-1:0] COORD_MIN = {1'b1, {CB-1{1'b0}}};

   // one candidate face as it travels over req; corner a is index 0
   typedef struct packed {
      logic [IB-1:0]        face_index;
      logic signed [CB-1:0] normal_comp;
      logic [2:0][IB-1:0]   vertex_id;
      logic [2:0][CB-1:0]   coord;
      logic                 last_face;
   } face_item_type;

   // one selection result as it travels over rsp
   typedef struct packed {
      logic [FACE_OUT_BITS-1:0] outer_face;
      logic                     flip_needed;
      logic                     found;
   } facet_choice_type;

   logic clock = 1'b0;
   logic reset;

   ofs_req_if #(.INDEX_BITS(IB), .COORD_BITS(CB)) req_bus ();
   ofs_rsp_if rsp_bus ();

   outer_facet_select #(.INDEX_BITS(IB), .COORD_BITS(CB)) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predicted selections, oldest first
   facet_choice_type expected_choices[$];
   int unsigned      error_count = 0;
   int unsigned      cycle_count = 0;

   // idling control: quiet turns off all random gaps and stalls
   bit quiet = 1'b0;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int stall_left = 0;

   // predictor copy of the leading corner
   logic                 top_held;
   logic [IB-1:0]        top_vertex;
   logic signed [CB-1:0] top_coord;
   logic [IB-1:0]        top_face;
   logic [CB-1:0]        top_mag;
   logic                 top_flip;

   function automatic void clear_lead();
      top_held   = 1'b0;
      top_vertex = '0;
      top_coord  = '0;
      top_face   = '0;
      top_mag    = '0;
      top_flip   = 1'b0;
   endfunction

   // one corner either competes on the normal (same vertex as the lead)
   // or tries to take the lead on a strictly greater coordinate
   function automatic void weigh_corner(logic [IB-1:0] face, logic [CB-1:0] mag, logic neg,
                                        logic [IB-1:0] vid, logic signed [CB-1:0] coord);
      if (top_held && vid == top_vertex) begin
         if (mag > top_mag) begin
            top_face = face;
            top_mag  = mag;
            top_flip = neg;
         end else if (mag == top_mag) begin
            // positive normal wins ties against a flipped lead or a lower face
            if (!neg) begin
               if (top_flip || face > top_face) begin
                  top_face = face;
                  top_flip = 1'b0;
               end
            end else if (top_flip && face < top_face) begin
               top_face = face;
            end
         end
         // the leading coordinate is left alone on a repeat
      end else if (!top_held || coord > top_coord) begin
         top_held   = 1'b1;
         top_vertex = vid;
         top_coord  = coord;
         top_face   = face;
         top_mag    = mag;
         top_flip   = neg;
      end
   endfunction

   // fold one accepted face into the lead; a last face yields a selection
   function automatic void absorb_face(face_item_type f);
      logic             neg;
      logic [CB-1:0]    mag;
      facet_choice_type choice;
      if (f.normal_comp != '0) begin
         neg = f.normal_comp[CB-1];
         // the most negative normal gives 2^(CB-1), which fits unsigned
         mag = neg ? CB'(-f.normal_comp) : CB'(f.normal_comp);
         for (int k = 0; k < 3; k++)
            weigh_corner(f.face_index, mag, neg, f.vertex_id[k], $signed(f.coord[k]));
      end
      if (f.last_face) begin
         choice.outer_face  = top_held ? FACE_OUT_BITS'(top_face) : '0;
         choice.flip_needed = top_held & top_flip;
         choice.found       = top_held;
         expected_choices.push_back(choice);
         clear_lead();
      end
   endfunction

   function automatic face_item_type make_face(logic [IB-1:0] face,
                                               logic signed [CB-1:0] normal,
                                               logic [IB-1:0] va, logic [IB-1:0] vb,
                                               logic [IB-1:0] vc, logic signed [CB-1:0] ca,
                                               logic signed [CB-1:0] cb,
                                               logic signed [CB-1:0] cc,
                                               logic last);
      face_item_type f;
      f.face_index  = face;
      f.normal_comp = normal;
      f.vertex_id   = {vc, vb, va};
      f.coord       = {cc, cb, ca};
      f.last_face   = last;
      return f;
   endfunction

   // narrow faces draw from small pools so vertex repeats, coordinate ties
   // and normal magnitude ties happen often; wide faces cover every bit
   function automatic face_item_type random_face(bit wide, logic last);
      face_item_type f;
      int            pick;
      logic [CB-1:0] mag;
      f.face_index = wide ? IB'($urandom) : IB'($urandom_range(0, 15));
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         f.normal_comp = '0;
      end else if (pick == 1 || wide) begin
         f.normal_comp = CB'($urandom);
      end else begin
         case ($urandom_range(0, 3))
            0: begin
               mag = CB'(1);
            end
            1: begin
               mag = CB'(2);
            end
            2: begin
               mag = CB'(32'h0001_0000);
            end
            default: begin
               mag = COORD_MAX;
            end
         endcase
         f.normal_comp = $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
      end
      for (int k = 0; k < 3; k++) begin
         f.vertex_id[k] = wide ? IB'($urandom) : IB'($urandom_range(0, 5));
         f.coord[k]     = wide ? CB'($urandom) : CB'(int'($urandom_range(0, 6)) - 3);
      end
      f.last_face = last;
      return f;
   endfunction

   // offer one face from a falling edge, optionally after an idle burst,
   // and return at the rising edge where it is taken
   task automatic send_face(face_item_type f);
      int gap;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         gap = $urandom_range(1, 5);
         repeat (gap) @(negedge clock);
      end
      req_bus.face_index  <= f.face_index;
      req_bus.normal_comp <= f.normal_comp;
      req_bus.vertex_id_a <= f.vertex_id[0];
      req_bus.vertex_id_b <= f.vertex_id[1];
      req_bus.vertex_id_c <= f.vertex_id[2];
      req_bus.coord_a     <= f.coord[0];
      req_bus.coord_b     <= f.coord[1];
      req_bus.coord_c     <= f.coord[2];
      req_bus.last_face   <= f.last_face;
      req_bus.valid       <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      absorb_face(f);
   endtask

   // a set of random length; the last face of it closes the set
   task automatic send_random_set(int max_len, bit allow_wide);
      int len;
      len = $urandom_range(1, max_len);
      for (int k = 0; k < len; k++)
         send_face(random_face(allow_wide && $urandom_range(0, 9) == 0, k == len - 1));
   endtask

   // extremes of every field, the most negative normal, skipped faces
   // and a set where nothing is found
   task automatic test_field_extremes();
      send_face(make_face(INDEX_MAX, COORD_MAX, INDEX_MAX, '0, INDEX_MAX,
                          COORD_MIN, COORD_MAX, '0, 1'b1));
      send_face(make_face('0, COORD_MIN, '0, INDEX_MAX, 5,
                          COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
      // lone zero-normal face: nothing found
      send_face(make_face(7, '0, 1, 2, 3, 1, 2, 3, 1'b1));
      // zero normal skipped ahead of a real face
      send_face(make_face(8, '0, 1, 2, 3, 9, 9, 9, 1'b0));
      send_face(make_face(9, -1, 4, 5, 6, -9, -8, -7, 1'b1));
   endtask

   // every tie rule on a repeat of the leading vertex, and proof that a
   // repeat leaves the leading coordinate alone
   task automatic test_lead_vertex_ties();
      send_face(make_face(20, -4, 9, 1, 2, 100, -50, -50, 1'b0));
      // equal negative, lead flipped, lower face: takes over
      send_face(make_face(15, -4, 9, 1, 2, 100, -50, -50, 1'b0));
      // equal negative, higher face: no change
      send_face(make_face(30, -4, 9, 1, 2, 100, -50, -50, 1'b0));
      // equal positive against a flipped lead: takes over, flip cleared
      send_face(make_face(25, 4, 9, 1, 2, 100, -50, -50, 1'b0));
      // equal positive, lower face: no change
      send_face(make_face(5, 4, 9, 1, 2, 100, -50, -50, 1'b0));
      // equal positive, higher face: takes over
      send_face(make_face(40, 4, 9, 1, 2, 100, -50, -50, 1'b0));
      // smaller magnitude: no change
      send_face(make_face(41, -2, 9, 1, 2, 100, -50, -50, 1'b0));
      // equal negative against an unflipped lead: no change
      send_face(make_face(42, -4, 9, 1, 2, 100, -50, -50, 1'b0));
      // larger magnitude: takes over
      send_face(make_face(43, 6, 9, 1, 2, 100, -50, -50, 1'b0));
      // repeat at a higher coordinate wins on the normal only
      send_face(make_face(44, -7, 9, 1, 2, 500, -50, -50, 1'b0));
      // beats the kept coordinate but not the repeated one
      send_face(make_face(45, 1, 3, 1, 2, 120, -50, -50, 1'b1));
      // repeat between corners of one face
      send_face(make_face(3, 1, 4, 4, 6, 10, 50, -20, 1'b1));
   endtask

   task automatic test_random_sets();
      int sent;
      sent = 0;
      while (sent < 330) begin
         send_random_set(8, 1'b1);
         sent = sent + 1;
      end
   endtask

   // result side blocked for a long stretch while faces keep coming,
   // so that the block fills and stalls req
   task automatic test_result_hold_off();
      hold_request = 1'b1;
      for (int k = 0; k < 40; k++)
         send_random_set(2, 1'b0);
   endtask

   // no idling at all on either side
   task automatic test_steady_stream();
      quiet = 1'b1;
      for (int k = 0; k < 40; k++)
         send_random_set(6, 1'b1);
   endtask

   // result side: long hold-off on request, short random stall bursts
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // compare each taken result with the oldest prediction
   always @(posedge clock) begin
      facet_choice_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_choices.size() == 0) begin
            $display("%0t: result with nothing expected: outer_face %0d flip %b found %b",
                     $time, rsp_bus.outer_face, rsp_bus.flip_needed, rsp_bus.found);
            error_count = error_count + 1;
         end else begin
            want = expected_choices.pop_front();
            if (rsp_bus.outer_face !== want.outer_face) begin
               $display("%0t: outer_face expected %0d actual %0d",
                        $time, want.outer_face, rsp_bus.outer_face);
               error_count = error_count + 1;
            end
            if (rsp_bus.flip_needed !== want.flip_needed) begin
               $display("%0t: flip_needed expected %b actual %b",
                        $time, want.flip_needed, rsp_bus.flip_needed);
               error_count = error_count + 1;
            end
            if (rsp_bus.found !== want.found) begin
               $display("%0t: found expected %b actual %b",
                        $time, want.found, rsp_bus.found);
               error_count = error_count + 1;
            end
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count = cycle_count + 1;
      end
      $display("outer_facet_select: mismatch");
      $finish;
   end

   initial begin
      // every block input known from time zero
      reset = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.face_index  = '0;
      req_bus.normal_comp = '0;
      req_bus.vertex_id_a = '0;
      req_bus.vertex_id_b = '0;
      req_bus.vertex_id_c = '0;
      req_bus.coord_a     = '0;
      req_bus.coord_b     = '0;
      req_bus.coord_c     = '0;
      req_bus.last_face   = 1'b0;
      rsp_bus.ready       = 1'b0;
      clear_lead();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_lead_vertex_ties();
      test_random_sets();
      test_result_hold_off();
      test_steady_stream();

      @(negedge clock);
      req_bus.valid <= 1'b0;

      // drain, then leave room for any stray result
      while (expected_choices.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("outer_facet_select: match");
      end else begin
         $display("outer_facet_select: mismatch");
      end
      $finish;
   end

endmodule
